// ----- hw/rtl/npc_pkg.sv -----
// Package for the nearest palette color matcher.
// Holds the queue transaction type, the sequencer states and the L1 distance helpers.
// No dependencies.
package npc_pkg;

   localparam int unsigned COLOR_W = 8;
   localparam int unsigned INDEX_W = 4;
   localparam int unsigned DIST_W  = 10;
   localparam int unsigned COUNT_W = 5;

   // Start value of the running minimum; above any real distance (max 765)
   localparam logic [DIST_W-1:0] DIST_START = 10'd1000;

   // Decoded kind of an input transaction
   typedef enum logic [1:0] {
      OP_WRITE,     // store a palette entry
      OP_DROP,      // write to a slot outside the palette, ignored
      OP_CLASSIFY   // search the palette for a pixel
   } op_type;

   // One decoded transaction as it sits in the queue
   typedef struct packed {
      op_type               op;
      logic [INDEX_W-1:0]   entry_index;
      logic [COLOR_W-1:0]   red;
      logic [COLOR_W-1:0]   green;
      logic [COLOR_W-1:0]   blue;
   } item_type;

   // Back-end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,   // take the next transaction from the queue
      ST_SCAN,   // issue one palette read per cycle
      ST_LAST,   // compare the last read entry
      ST_DONE    // hand the result to the output register
   } state_type;

   function automatic logic [COLOR_W-1:0] abs_diff8(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
      abs_diff8 = (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic logic [DIST_W-1:0] l1_dist(input logic [3*COLOR_W-1:0] entry,
                                                input logic [3*COLOR_W-1:0] pixel);
      logic [DIST_W-1:0] dr, dg, db;
      dr = DIST_W'(abs_diff8(entry[3*COLOR_W-1:2*COLOR_W], pixel[3*COLOR_W-1:2*COLOR_W]));
      dg = DIST_W'(abs_diff8(entry[2*COLOR_W-1:COLOR_W], pixel[2*COLOR_W-1:COLOR_W]));
      db = DIST_W'(abs_diff8(entry[COLOR_W-1:0], pixel[COLOR_W-1:0]));
      l1_dist = dr + dg + db;
   endfunction

endpackage

// ----- hw/rtl/nearest_palette_color_l1.sv -----
// Top level of the nearest palette color matcher (L1 distance).
// Instantiates npc_front and npc_back and holds the palette_count register. Uses npc_pkg.
//
// Usage:
//  - Input channel req_*: a transaction moves when req_valid and req_ready are high.
//    req_action 0 writes {red, green, blue} to palette slot req_entry_index (no
//    result); req_action 1 classifies the pixel {red, green, blue}.
//  - Result channel rsp_*: one transaction per classify: nearest index, its summed
//    absolute RGB difference and found (0 with zero fields when nothing is searched).
//  - csr_we/csr_wdata writes palette_count, the number of entries searched from slot 0,
//    capped at PALETTE_ENTRIES. Write it only while the block is idle.
//  - Timing: a two-entry queue sits behind req_ready. The back end scans the palette
//    memory one entry per cycle, through the first N entries, N being palette_count
//    capped at PALETTE_ENTRIES, then compares the last entry and loads the result
//    register; with an empty palette it skips the scan. A write is done in ST_IDLE.
//  - A stalled result waits in the output register; writes keep flowing and the next
//    classify scans, then waits for the register to free up.
//  - Reset clears palette_count and empties the queue; palette entries are undefined
//    until written.
module nearest_palette_color_l1 import npc_pkg::*; #(
   parameter int unsigned PALETTE_ENTRIES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_action,
   input  logic [INDEX_W-1:0]  req_entry_index,
   input  logic [COLOR_W-1:0]  req_red,
   input  logic [COLOR_W-1:0]  req_green,
   input  logic [COLOR_W-1:0]  req_blue,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [INDEX_W-1:0]  rsp_match_index,
   output logic [DIST_W-1:0]   rsp_distance,
   output logic                rsp_found,
   input  logic                csr_we,
   input  logic [COUNT_W-1:0]  csr_wdata
);

   logic [COUNT_W-1:0]  palette_count_ff, palette_count_in;
   logic                q_valid;
   item_type            q_item;
   logic                q_pop;

   // palette_count register
   assign palette_count_in = csr_we ? csr_wdata : palette_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_count_ff <= '0;
      end else begin
         palette_count_ff <= palette_count_in;
      end
   end

   npc_front #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_entry_index (req_entry_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   npc_back #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .palette_count   (palette_count_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_match_index (rsp_match_index),
      .rsp_distance    (rsp_distance),
      .rsp_found       (rsp_found)
   );

endmodule

// ----- hw/rtl/npc_front.sv -----
// Front end of the nearest palette color matcher: accepts input transactions,
// decodes them and holds them in a two-entry queue for the back end. Uses npc_pkg.
module npc_front import npc_pkg::*; #(
   parameter int unsigned PALETTE_ENTRIES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_action,
   input  logic [INDEX_W-1:0]  req_entry_index,
   input  logic [COLOR_W-1:0]  req_red,
   input  logic [COLOR_W-1:0]  req_green,
   input  logic [COLOR_W-1:0]  req_blue,
   output logic                q_valid,
   output item_type            q_item,
   input  logic                q_pop
);

   item_type    slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   item_type    dec_item;

   // Decode: classify, write, or write outside the palette
   always_comb begin
      dec_item.entry_index = req_entry_index;
      dec_item.red         = req_red;
      dec_item.green       = req_green;
      dec_item.blue        = req_blue;
      if (req_action) begin
         dec_item.op = OP_CLASSIFY;
      end else if (32'(req_entry_index) < 32'(PALETTE_ENTRIES)) begin
         dec_item.op = OP_WRITE;
      end else begin
         dec_item.op = OP_DROP;
      end
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   // Queue pointers and fill level
   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec_item;
      end
   end

   q_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   q_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue fill level out of range");

   q_level_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue fill level did not follow a push");

endmodule

// ----- hw/rtl/npc_back.sv -----
// Back end of the nearest palette color matcher: palette memory, a sequencer
// that scans one entry per cycle with a running minimum, and the result register.
// Uses npc_pkg.
module npc_back import npc_pkg::*; #(
   parameter int unsigned PALETTE_ENTRIES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  item_type            q_item,
   output logic                q_pop,
   input  logic [COUNT_W-1:0]  palette_count,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [INDEX_W-1:0]  rsp_match_index,
   output logic [DIST_W-1:0]   rsp_distance,
   output logic                rsp_found
);

   localparam int unsigned AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int unsigned CW = $clog2(PALETTE_ENTRIES + 1);

   logic [3*COLOR_W-1:0] pal_mem [PALETTE_ENTRIES];

   state_type             state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in, cnt_next;
   logic [CW-1:0]         lim_ff, lim_in, lim_eff;
   logic [3*COLOR_W-1:0]  pix_ff, pix_in;
   logic [3*COLOR_W-1:0]  rd_data_ff;
   logic                  rd_vld_ff, rd_vld_in;
   logic [AW-1:0]         rd_idx_ff;
   logic [DIST_W-1:0]     best_dist_ff, best_dist_in;
   logic [AW-1:0]         best_idx_ff, best_idx_in;
   logic                  found_ff, found_in;
   logic                  mem_we;
   logic [DIST_W-1:0]     cur_dist;
   logic                  load_out;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]    out_idx_ff;
   logic [DIST_W-1:0]     out_dist_ff;
   logic                  out_found_ff;

   // Entries searched: the register, capped at the palette size
   assign lim_eff  = (32'(palette_count) > 32'(PALETTE_ENTRIES)) ?
                     CW'(PALETTE_ENTRIES) : CW'(palette_count);
   assign cnt_next = cnt_ff + CW'(1);
   assign cur_dist = l1_dist(rd_data_ff, pix_ff);

   // Sequencer and running minimum
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      lim_in       = lim_ff;
      pix_in       = pix_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      found_in     = found_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      load_out     = 1'b0;
      rd_vld_in    = (state_ff == ST_SCAN);

      // compare the entry read last cycle; strict less-than keeps the lowest index
      if (rd_vld_ff && (cur_dist < best_dist_ff)) begin
         best_dist_in = cur_dist;
         best_idx_in  = rd_idx_ff;
         found_in     = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_item.op)
                  OP_WRITE: begin
                     mem_we = 1'b1;
                  end
                  OP_CLASSIFY: begin
                     pix_in       = {q_item.red, q_item.green, q_item.blue};
                     lim_in       = lim_eff;
                     cnt_in       = '0;
                     best_dist_in = DIST_START;
                     best_idx_in  = '0;
                     found_in     = 1'b0;
                     state_in     = (lim_eff == '0) ? ST_DONE : ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_next;
            if (cnt_next == lim_ff) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || load_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      lim_ff       <= lim_in;
      pix_ff       <= pix_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      found_ff     <= found_in;
      rd_idx_ff    <= cnt_ff[AW-1:0];
      if (load_out) begin
         out_found_ff <= found_ff;
         out_idx_ff   <= found_ff ? INDEX_W'(best_idx_ff) : '0;
         out_dist_ff  <= found_ff ? best_dist_ff : '0;
      end
   end

   // Palette memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pal_mem[AW'(q_item.entry_index)] <= {q_item.red, q_item.green, q_item.blue};
      end
      rd_data_ff <= pal_mem[cnt_ff[AW-1:0]];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_index = out_idx_ff;
   assign rsp_distance    = out_dist_ff;
   assign rsp_found       = out_found_ff;

   pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE))
      else $error("queue popped while a search is running");

   scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff < lim_ff))
      else $error("scan address past the searched entries");

   found_dist_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found) |-> (rsp_distance <= 10'd765))
      else $error("matched distance out of range");

   empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found) |-> (rsp_distance == '0 && rsp_match_index == '0))
      else $error("empty search result not cleared");

endmodule

// ----- bench/npc_tb_pkg.sv -----
// Shared definitions for the nearest palette color matcher testbench.
// Holds the action codes and the record of one expected match result.
// Depends on npc_pkg for the field widths.
package npc_tb_pkg;
   import npc_pkg::*;

   // Values of req_action
   localparam logic ACTION_WRITE    = 1'b0;
   localparam logic ACTION_CLASSIFY = 1'b1;

   // One result transaction as the block should return it
   typedef struct packed {
      logic [INDEX_W-1:0] match_index;
      logic [DIST_W-1:0]  distance;
      logic               found;
   } match_result_type;

endpackage

// ----- bench/npc_match_checker.sv -----
// Checker for the nearest palette color matcher: watches both channels and the
// palette_count write port, predicts each match and compares it field by field.
// Depends on npc_pkg and npc_tb_pkg.
module npc_match_checker import npc_pkg::*, npc_tb_pkg::*; #(
   parameter int unsigned PALETTE_ENTRIES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_action,
   input  logic [INDEX_W-1:0]  req_entry_index,
   input  logic [COLOR_W-1:0]  req_red,
   input  logic [COLOR_W-1:0]  req_green,
   input  logic [COLOR_W-1:0]  req_blue,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [INDEX_W-1:0]  rsp_match_index,
   input  logic [DIST_W-1:0]   rsp_distance,
   input  logic                rsp_found,
   input  logic                csr_we,
   input  logic [COUNT_W-1:0]  csr_wdata,
   output int                  fail_count,
   output int                  outstanding
);

   // Shadow of the palette as {red, green, blue} and of the searched count
   logic [3*COLOR_W-1:0] palette_shadow [PALETTE_ENTRIES];
   logic [COUNT_W-1:0]   searched_count;
   match_result_type     pending_matches [$];

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("%0t: result error: %s", $time, msg);
   endtask

   function automatic int color_gap(input logic [COLOR_W-1:0] a, input logic [COLOR_W-1:0] b);
      return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
   endfunction

   // Linear search; strict less-than keeps the lowest index on a tie
   function automatic match_result_type nearest_entry(input logic [COLOR_W-1:0] r,
                                                      input logic [COLOR_W-1:0] g,
                                                      input logic [COLOR_W-1:0] b);
      match_result_type best;
      int limit;
      int best_dist;
      int d;
      best      = '0;
      best_dist = int'(DIST_START);
      limit     = (searched_count > PALETTE_ENTRIES) ? PALETTE_ENTRIES : int'(searched_count);
      for (int i = 0; i < limit; i++) begin
         d = color_gap(palette_shadow[i][3*COLOR_W-1:2*COLOR_W], r)
           + color_gap(palette_shadow[i][2*COLOR_W-1:COLOR_W], g)
           + color_gap(palette_shadow[i][COLOR_W-1:0], b);
         if (d < best_dist) begin
            best_dist         = d;
            best.match_index  = INDEX_W'(i);
            best.distance     = DIST_W'(d);
            best.found        = 1'b1;
         end
      end
      return best;
   endfunction

   // Compare before predicting, so a result never pairs with a same-cycle request
   always @(posedge clock) begin
      match_result_type want;
      if (reset) begin
         searched_count = '0;
         pending_matches.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_matches.size() == 0) begin
               report_mismatch($sformatf("transaction with none pending (index %0d, dist %0d)",
                                         rsp_match_index, rsp_distance));
            end else begin
               want = pending_matches.pop_front();
               if (rsp_match_index !== want.match_index)
                  report_mismatch($sformatf("match_index got %0d, expected %0d",
                                            rsp_match_index, want.match_index));
               if (rsp_distance !== want.distance)
                  report_mismatch($sformatf("distance got %0d, expected %0d",
                                            rsp_distance, want.distance));
               if (rsp_found !== want.found)
                  report_mismatch($sformatf("found got %0d, expected %0d",
                                            rsp_found, want.found));
            end
         end
         if (req_valid && req_ready) begin
            if (req_action == ACTION_WRITE) begin
               if (req_entry_index < PALETTE_ENTRIES)
                  palette_shadow[req_entry_index] = {req_red, req_green, req_blue};
            end else begin
               pending_matches.push_back(nearest_entry(req_red, req_green, req_blue));
            end
         end
         if (csr_we)
            searched_count = csr_wdata;
      end
      outstanding <= pending_matches.size();
   end

endmodule

// ----- bench/nearest_palette_color_l1_tb.sv -----
// Testbench top for the nearest palette color matcher: directed palette cases,
// then random writes and pixels over several palette sizes with random stalls.
// Depends on npc_pkg, npc_tb_pkg, npc_match_checker and the block itself.
module nearest_palette_color_l1_tb;
   import npc_pkg::*;
   import npc_tb_pkg::*;

   localparam int PALETTE_ENTRIES = 16;
   localparam int SETTLE_CYCLES   = 40;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_AFTER      = 200;
   localparam int HOLD_CYCLES     = 300;
   localparam int PHASE_ITEMS     = 55;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_action      = ACTION_WRITE;
   logic [INDEX_W-1:0]  req_entry_index = '0;
   logic [COLOR_W-1:0]  req_red         = '0;
   logic [COLOR_W-1:0]  req_green       = '0;
   logic [COLOR_W-1:0]  req_blue        = '0;
   logic                rsp_ready       = 1'b0;
   logic                csr_we          = 1'b0;
   logic [COUNT_W-1:0]  csr_wdata       = '0;
   logic                req_ready;
   logic                rsp_valid;
   logic [INDEX_W-1:0]  rsp_match_index;
   logic [DIST_W-1:0]   rsp_distance;
   logic                rsp_found;

   int fail_count;
   int outstanding;
   int items_sent  = 0;
   int cycle_count = 0;
   bit sender_gaps = 1'b1;

   initial begin
      forever #5 clock = ~clock;
   end

   nearest_palette_color_l1 #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_entry_index (req_entry_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_match_index (rsp_match_index),
      .rsp_distance    (rsp_distance),
      .rsp_found       (rsp_found),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   npc_match_checker #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) match_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_entry_index (req_entry_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_match_index (rsp_match_index),
      .rsp_distance    (rsp_distance),
      .rsp_found       (rsp_found),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .outstanding     (outstanding)
   );

   // Mostly no gap, often a short one, now and then a long one
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return 0;
      else if (pick < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // Extremes and mid-gray often, so ties and zero distances come up
   function automatic logic [COLOR_W-1:0] pick_color();
      case ($urandom_range(0, 9))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         2: begin
            return 8'd128;
         end
         default: begin
            return COLOR_W'($urandom_range(0, 255));
         end
      endcase
   endfunction

   // Offer one transaction and hold it until accepted
   task automatic send_item(input logic action, input logic [INDEX_W-1:0] slot,
                            input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                            input logic [COLOR_W-1:0] b);
      int gap;
      gap = sender_gaps ? gap_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= action;
      req_entry_index <= slot;
      req_red         <= r;
      req_green       <= g;
      req_blue        <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_random_item();
      logic action;
      action = ($urandom_range(0, 9) < 3) ? ACTION_WRITE : ACTION_CLASSIFY;
      send_item(action, INDEX_W'($urandom_range(0, 15)), pick_color(), pick_color(),
                pick_color());
   endtask

   // Drain all results plus settle time for in-flight writes, then write the register
   task automatic set_palette_count(input logic [COUNT_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Result side: random stalls, one long hold-off once the traffic is going
   initial begin
      int  stall;
      int  run;
      bit  held;
      held = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!held && items_sent >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = gap_length();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         // ready window, cut short as soon as the long hold-off is due
         if (held || items_sent < HOLD_AFTER) begin
            rsp_ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? 60 : int'($urandom_range(1, 6));
            for (int k = 0; k < run && (held || items_sent < HOLD_AFTER); k++)
               @(posedge clock);
         end
      end
   end

   // Run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // Stimulus and verdict
   initial begin
      logic [COUNT_W-1:0] phase_counts [10];
      phase_counts    = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd17, 5'd16, 5'd2, 5'd8, 5'd30, 5'd15};
      phase_counts[7] = COUNT_W'($urandom_range(0, 31));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Empty palette after reset: nothing found
      send_item(ACTION_CLASSIFY, 4'd0, 8'd0, 8'd0, 8'd0);
      send_item(ACTION_CLASSIFY, 4'd15, 8'd255, 8'd255, 8'd255);

      // Fill every slot; slots 5 and 6 hold the same gray for a tie
      send_item(ACTION_WRITE, 4'd0, 8'd0, 8'd0, 8'd0);
      send_item(ACTION_WRITE, 4'd1, 8'd255, 8'd255, 8'd255);
      send_item(ACTION_WRITE, 4'd2, 8'd255, 8'd0, 8'd0);
      send_item(ACTION_WRITE, 4'd3, 8'd0, 8'd255, 8'd0);
      send_item(ACTION_WRITE, 4'd4, 8'd0, 8'd0, 8'd255);
      send_item(ACTION_WRITE, 4'd5, 8'd128, 8'd128, 8'd128);
      send_item(ACTION_WRITE, 4'd6, 8'd128, 8'd128, 8'd128);
      for (int i = 7; i < PALETTE_ENTRIES; i++)
         send_item(ACTION_WRITE, INDEX_W'(i), COLOR_W'($urandom_range(0, 255)),
                   COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)));

      // Single black entry against white: largest distance
      set_palette_count(5'd1);
      send_item(ACTION_CLASSIFY, 4'd0, 8'd255, 8'd255, 8'd255);

      // Full palette: exact hits and ties
      set_palette_count(5'd16);
      send_item(ACTION_CLASSIFY, 4'd0, 8'd128, 8'd128, 8'd128);
      send_item(ACTION_CLASSIFY, 4'd0, 8'd64, 8'd64, 8'd64);
      send_item(ACTION_CLASSIFY, 4'd0, 8'd255, 8'd0, 8'd0);
      send_item(ACTION_CLASSIFY, 4'd0, 8'd0, 8'd0, 8'd0);

      // Random traffic over several palette sizes, some phases back to back
      for (int p = 0; p < 10; p++) begin
         set_palette_count(phase_counts[p]);
         sender_gaps = (p % 4 != 2);
         repeat (PHASE_ITEMS) send_random_item();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/npc_pkg.sv
hw/rtl/npc_front.sv
hw/rtl/npc_back.sv
hw/rtl/nearest_palette_color_l1.sv
bench/npc_tb_pkg.sv
bench/npc_match_checker.sv
bench/nearest_palette_color_l1_tb.sv
